/* rtl/length_prefixed_frame_receiver_unit_defines.svh */
// Assertion macros used by the frame receiver core.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LPFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpfr: implication check failed");
// Next-cycle implication, checked outside reset.
`define LPFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpfr: next-cycle check failed");
`else
`define LPFR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/lpfr_pkg.sv */
// Shared types and constants of the frame receiver.
package lpfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned KEPT_W = 9;

  // Largest number of payload bytes passed on per frame.
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 16'd256;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd62;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_valid;
    logic              frame_done;
    logic              truncated;
    logic [KEPT_W-1:0] kept_length;
    logic [LEN_W-1:0]  declared_length;
  } result_t;

endpackage

/* rtl/lpfr_if.sv */
// Handshake channels of the frame receiver: received bytes in, results out.
interface lpfr_rx_if;
  logic                      valid;
  logic                      ready;
  logic [lpfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [lpfr_pkg::BYTE_W-1:0] payload_byte;
  logic                        byte_valid;
  logic                        frame_done;
  logic                        truncated;
  logic [lpfr_pkg::KEPT_W-1:0] kept_length;
  logic [lpfr_pkg::LEN_W-1:0]  declared_length;

  modport source (output valid, output payload_byte, output byte_valid,
                  output frame_done, output truncated, output kept_length,
                  output declared_length, input ready);
  modport sink   (input valid, input payload_byte, input byte_valid,
                  input frame_done, input truncated, input kept_length,
                  input declared_length, output ready);
endinterface

/* rtl/length_prefixed_frame_receiver_unit.sv */
// Top level of the length-prefixed frame receiver.
// The receiver takes one byte beat per cycle on rx. It hunts for the start
// marker (register start_marker, reset 0x3E), then reads a 16-bit length,
// low byte first. A zero length drops back to hunting. A nonzero length is
// followed by exactly that many payload bytes; the first MAX_PAYLOAD (256)
// of them leave on res as beats with byte_valid set. The byte that completes
// the frame carries frame_done with kept_length, declared_length and
// truncated; bytes past the limit that do not complete the frame give no
// beat. Header bytes never give a beat, and a marker value inside a frame is
// plain data. Each accepted byte is parsed in the cycle it is accepted,
// against the registered frame state, and its beat, if any, sits in a single
// result register from the next cycle on. rx stays ready while that register
// is empty or being read, so a full rate of one byte per cycle is held as
// long as res is ready; a stalled res beat holds off rx, header and dropped
// bytes included, until it leaves.
// Write start_marker only while no frame is in flight.
module length_prefixed_frame_receiver_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lpfr_pkg::BYTE_W-1:0] cfg_wdata,
  lpfr_rx_if.sink                     rx,
  lpfr_res_if.source                  res
);

  logic              accept;
  logic              can_take;
  logic              parse_valid;
  lpfr_pkg::result_t parse_res;
  lpfr_pkg::result_t hold_res;

  // Accept a beat whenever the result register has room for it.
  assign rx.ready = can_take;
  assign accept   = rx.valid && can_take;

  lpfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .res_valid (parse_valid),
    .res       (parse_res)
  );

  lpfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (parse_valid),
    .take       (accept),
    .load_data  (parse_res),
    .out_ready  (res.ready),
    .can_take   (can_take),
    .out_valid  (res.valid),
    .out_data   (hold_res)
  );

  // Unpack the held result onto the channel.
  assign res.payload_byte    = hold_res.payload_byte;
  assign res.byte_valid      = hold_res.byte_valid;
  assign res.frame_done      = hold_res.frame_done;
  assign res.truncated       = hold_res.truncated;
  assign res.kept_length     = hold_res.kept_length;
  assign res.declared_length = hold_res.declared_length;

endmodule

/* rtl/lpfr_core.sv */
// Frame parser: marker hunt, length header, payload count and result build.
`include "length_prefixed_frame_receiver_unit_defines.svh"

module lpfr_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lpfr_pkg::BYTE_W-1:0] cfg_wdata,
  input  logic                        accept,
  input  logic [lpfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                        res_valid,
  output lpfr_pkg::result_t           res
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA
  } phase_t;

  phase_t                       phase, phase_next;
  logic [lpfr_pkg::BYTE_W-1:0]  start_marker;
  logic [lpfr_pkg::LEN_W-1:0]   frame_length, frame_length_next;
  logic [lpfr_pkg::LEN_W-1:0]   received_count, received_count_next;
  logic [lpfr_pkg::LEN_W-1:0]   count_inc;
  logic [lpfr_pkg::LEN_W-1:0]   kept_full;
  logic                         kept;
  logic                         done;
  logic                         over;

  assign count_inc = received_count + 16'd1;
  assign kept      = received_count < lpfr_pkg::MAX_PAYLOAD;
  assign done      = count_inc >= frame_length;
  assign over      = frame_length > lpfr_pkg::MAX_PAYLOAD;
  assign kept_full = over ? lpfr_pkg::MAX_PAYLOAD : frame_length;

  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    received_count_next = received_count;
    res_valid           = 1'b0;
    res                 = '0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == start_marker) begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        frame_length_next = {8'd0, rx_byte};
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next   = {rx_byte, frame_length[lpfr_pkg::BYTE_W-1:0]};
        received_count_next = '0;
        phase_next = (frame_length_next != '0) ? PH_DATA : PH_HUNT;
      end
      PH_DATA: begin
        received_count_next = count_inc;
        res_valid           = kept || done;
        res.byte_valid      = kept;
        res.payload_byte    = kept ? rx_byte : '0;
        res.frame_done      = done;
        if (done) begin
          res.truncated       = over;
          res.kept_length     = kept_full[lpfr_pkg::KEPT_W-1:0];
          res.declared_length = frame_length;
          phase_next          = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      frame_length   <= '0;
      received_count <= '0;
      start_marker   <= lpfr_pkg::START_MARKER_RESET;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        frame_length   <= frame_length_next;
        received_count <= received_count_next;
      end
      if (cfg_we) begin
        start_marker <= cfg_wdata;
      end
    end
  end

  `LPFR_ASSERT_IMPL(a_result_only_in_data, clk, rst, res_valid, phase == PH_DATA)
  `LPFR_ASSERT_IMPL(a_data_len_nonzero, clk, rst, phase == PH_DATA, frame_length != '0)
  `LPFR_ASSERT_NEXT(a_done_rehunts, clk, rst, accept && res_valid && res.frame_done, phase == PH_HUNT)
  `LPFR_ASSERT_IMPL(a_trunc_len, clk, rst, res_valid && res.truncated, res.kept_length == lpfr_pkg::MAX_PAYLOAD[lpfr_pkg::KEPT_W-1:0])

endmodule

/* rtl/lpfr_out_reg.sv */
// Result register between the parser and the output channel.
module lpfr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  logic              take,
  input  lpfr_pkg::result_t load_data,
  input  logic              out_ready,
  output logic              can_take,
  output logic              out_valid,
  output lpfr_pkg::result_t out_data
);

  // Free when empty or drained in this cycle.
  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

/* tb/length_prefixed_frame_receiver_checker.sv */
// Checker for the frame receiver: predicts every result beat and compares it on arrival.
module length_prefixed_frame_receiver_checker
  import lpfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  lpfr_rx_if                rx,
  lpfr_res_if               res,
  output int unsigned       mismatches,
  output int unsigned       pending,
  output int unsigned       beats_checked,
  output int unsigned       frames_done,
  output int unsigned       truncated_frames
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD
  } deframe_phase_t;

  deframe_phase_t    phase;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  rcv_count;
  logic [BYTE_W-1:0] marker;
  result_t           expected_beats [$];
  int unsigned       mismatch_tally = 0;
  int unsigned       beat_tally     = 0;
  int unsigned       frame_tally    = 0;
  int unsigned       trunc_tally    = 0;

  function automatic string beat_text(input result_t r);
    return $sformatf("byte %02h valid %0b done %0b trunc %0b kept %0d declared %0d",
                     r.payload_byte, r.byte_valid, r.frame_done, r.truncated,
                     r.kept_length, r.declared_length);
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatch_tally++;
    if (mismatch_tally <= 10) begin
      $display("[%0t] %s: expected %s", $time, what, beat_text(want));
      $display("[%0t] %s: actual   %s", $time, what, beat_text(got));
    end
  endtask

  // Advance the deframer by one received byte and queue the beat it causes, if any.
  task automatic advance_deframer(input logic [BYTE_W-1:0] b);
    logic             kept;
    logic             done;
    logic             over;
    logic [LEN_W-1:0] kept_full;
    result_t          beat;
    case (phase)
      PH_HUNT: begin
        if (b == marker) phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len = {8'h00, b};
        phase     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len[LEN_W-1:BYTE_W] = b;
        rcv_count = '0;
        phase     = (frame_len != '0) ? PH_PAYLOAD : PH_HUNT;
      end
      default: begin
        kept      = (rcv_count < MAX_PAYLOAD);
        rcv_count = rcv_count + 16'd1;
        done      = (rcv_count >= frame_len);
        if (kept || done) begin
          beat = '0;
          if (kept) begin
            beat.payload_byte = b;
            beat.byte_valid   = 1'b1;
          end
          if (done) begin
            over      = (frame_len > MAX_PAYLOAD);
            kept_full = over ? MAX_PAYLOAD : frame_len;
            beat.frame_done      = 1'b1;
            beat.truncated       = over;
            beat.kept_length     = kept_full[KEPT_W-1:0];
            beat.declared_length = frame_len;
            phase = PH_HUNT;
            frame_tally++;
            if (over) trunc_tally++;
          end
          expected_beats.push_back(beat);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      phase     = PH_HUNT;
      frame_len = '0;
      rcv_count = '0;
      marker    = START_MARKER_RESET;
      expected_beats.delete();
    end else begin
      // Compare first: a beat can never leave in the cycle its byte arrives.
      if (res.valid && res.ready) begin
        got.payload_byte    = res.payload_byte;
        got.byte_valid      = res.byte_valid;
        got.frame_done      = res.frame_done;
        got.truncated       = res.truncated;
        got.kept_length     = res.kept_length;
        got.declared_length = res.declared_length;
        beat_tally++;
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing expected", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) report_mismatch("beat mismatch", want, got);
        end
      end
      if (rx.valid && rx.ready) advance_deframer(rx.rx_byte);
      if (cfg_we) marker = cfg_wdata;
    end
    mismatches       <= mismatch_tally;
    pending          <= $unsigned(expected_beats.size());
    beats_checked    <= beat_tally;
    frames_done      <= frame_tally;
    truncated_frames <= trunc_tally;
  end

endmodule

/* tb/length_prefixed_frame_receiver_unit_tb.sv */
// Testbench top for the frame receiver: drives bytes and the start marker, then gives the verdict.
module length_prefixed_frame_receiver_unit_tb;
  import lpfr_pkg::*;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [BYTE_W-1:0] cfg_wdata = '0;

  // Chance in a hundred that the sender holds off a beat, or the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Marker the block currently hunts for; kept here to shape frames and noise.
  logic [BYTE_W-1:0] cur_marker = START_MARKER_RESET;
  int unsigned       bytes_sent = 0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned beats_checked;
  int unsigned frames_done;
  int unsigned truncated_frames;

  // Hand-picked opening sequence under the reset marker 0x3E: noise while
  // hunting, a zero-length header, one-byte frame, a marker value inside the
  // payload, and a plain two-byte frame.
  logic [BYTE_W-1:0] directed_bytes [$] = '{
    8'h00, 8'hFF,
    8'h3E, 8'h00, 8'h00,
    8'h3E, 8'h01, 8'h00, 8'hFF,
    8'h3E, 8'h03, 8'h00, 8'h00, 8'h3E, 8'hA5,
    8'h3E, 8'h02, 8'h00, 8'h55, 8'hAA
  };

  lpfr_rx_if  rx_ch ();
  lpfr_res_if res_ch ();

  length_prefixed_frame_receiver_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  length_prefixed_frame_receiver_checker checker_inst (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .rx               (rx_ch),
    .res              (res_ch),
    .mismatches       (mismatches),
    .pending          (pending),
    .beats_checked    (beats_checked),
    .frames_done      (frames_done),
    .truncated_frames (truncated_frames)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result-side backpressure: redraw ready at every edge from the current stall rate.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("Run timed out with %0d beats still expected", pending);
    $display("TEST FAILED");
    $finish;
  end

  // Send one byte beat. Enter and leave at a rising edge; valid stays high on
  // exit so back-to-back beats follow without a gap.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    // Values read right after the edge are the ones the edge sampled.
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  // Send a whole frame: marker, length low then high, then the payload.
  task automatic send_frame(input logic [LEN_W-1:0] len);
    send_byte(cur_marker);
    send_byte(len[BYTE_W-1:0]);
    send_byte(len[LEN_W-1:BYTE_W]);
    for (int unsigned i = 0; i < len; i++) begin
      // Drop the marker value into the payload now and then; it must pass as data.
      if ($urandom_range(9) == 0) send_byte(cur_marker);
      else send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  // Change the start marker only once the block is idle: drop valid, let every
  // expected beat drain, then let the pipeline settle before the write.
  task automatic set_marker(input logic [BYTE_W-1:0] m);
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_marker = m;
  endtask

  // Random frames until the byte budget is used up. Most frames are short,
  // some are mid-sized, a few sit around the keep limit, some are zero-length,
  // and noise bytes that never match the marker fall between them. The forced
  // length is sent once in every call.
  task automatic run_frames(input int unsigned byte_budget, input logic [LEN_W-1:0] forced_len);
    int unsigned       start_count;
    int unsigned       pick;
    logic              forced_sent;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] noise;
    start_count = bytes_sent;
    forced_sent = 1'b0;
    while (bytes_sent - start_count < byte_budget) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          noise = BYTE_W'($urandom_range(255));
          if (noise == cur_marker) noise = noise ^ 8'h01;
          send_byte(noise);
        end
      end
      pick = $urandom_range(99);
      if (!forced_sent && pick < 8) begin
        len         = forced_len;
        forced_sent = 1'b1;
      end else if (pick < 14) begin
        len = '0;
      end else if (pick < 17) begin
        len = LEN_W'($urandom_range(262, 250));
      end else if (pick < 35) begin
        len = LEN_W'($urandom_range(40, 9));
      end else begin
        len = LEN_W'($urandom_range(8, 1));
      end
      send_frame(len);
    end
    if (!forced_sent) send_frame(forced_len);
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;

    // Hold reset at the start of the run, once.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, reset marker, sender idles lightly, receiver heavily.
    send_idle_pct = 25;
    recv_idle_pct = 68;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Marker 0x00: the zero high length byte of short frames now equals the
    // marker, so a marker inside the header gets exercised. Force one frame
    // just past the keep limit.
    set_marker(8'h00);
    run_frames(16, 16'd257);

    // Marker 0xFF, idle rates swapped; force a frame of exactly the limit.
    send_idle_pct = 68;
    recv_idle_pct = 25;
    set_marker(8'hFF);
    run_frames(16, 16'd256);

    // Random marker at full rate on both sides; mostly short frames.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_marker(BYTE_W'($urandom_range(255)));
    run_frames(40, 16'd12);

    // Drain: wait for every expected beat, then wait on for any stray beats.
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes; checked %0d result beats over %0d frames, %0d of them truncated.",
             bytes_sent, beats_checked, frames_done, truncated_frames);
    $display("Markers 0x3E, 0x00, 0xFF and 0x%02h under three idle profiles; %0d mismatches.",
             cur_marker, mismatches);
    if (pending != 0) $display("%0d expected beats never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
